@@ rtl/bmf_pkg.sv @@
// Package for the block median filter: sizes, cell link and control types.
package bmf_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned Window  = 21;
  localparam int unsigned MidIdx  = Window / 2;
  localparam int unsigned CountW  = (Window > 1) ? $clog2(Window) : 1;
  localparam int unsigned TdataW  = ((SampleW + 7) / 8) * 8;

  typedef logic [SampleW-1:0] sample_t;
  typedef logic [CountW-1:0]  count_t;

  // What one cell shows its right-hand neighbour.
  typedef struct packed {
    sample_t val;
    logic    vld;
    logic    gt;   // cell is empty or holds a value above the incoming sample
  } link_t;

  // Control broadcast to every cell.
  typedef struct packed {
    logic en;      // a sample beat is taken this cycle
    logic clr;     // this beat is the group's last, so taking it empties all cells
  } cell_ctrl_t;

endpackage

@@ rtl/bmf_cell.sv @@
// One cell of the sorted insertion chain.
module bmf_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bmf_pkg::cell_ctrl_t ctrl_i,
  input  bmf_pkg::sample_t   sample_i,
  input  bmf_pkg::link_t     prev_i,
  output bmf_pkg::link_t     link_o,
  output bmf_pkg::sample_t   val_d_o
);

  bmf_pkg::sample_t val_q, val_d;
  logic             vld_q, vld_d;
  logic             gt;

  // The chain stays sorted ascending with empty cells at the end, so the
  // gt flags along the chain form a run of zeros followed by ones.
  assign gt = !vld_q || (val_q > sample_i);

  always_comb begin
    val_d = val_q;
    vld_d = vld_q;
    if (ctrl_i.en) begin
      if (gt && prev_i.gt) begin
        val_d = prev_i.val;
        vld_d = prev_i.vld;
      end else if (gt) begin
        val_d = sample_i;
        vld_d = 1'b1;
      end
      if (ctrl_i.clr) begin
        vld_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign link_o  = '{val: val_q, vld: vld_q, gt: gt};
  assign val_d_o = val_d;

endmodule

@@ rtl/block_median_filter_core.sv @@
// Top level of the block median filter: insertion chain, group counter, output register.
//
//   channel   dir  tdata bits                 meaning
//   s_axis    in   [11:0] sample, rest zero   one converter sample per beat
//   m_axis    out  [11:0] median, rest zero   median of each completed group
//
// One sample beat is taken per cycle; every sample is inserted in sorted
// order into a chain of Window cells in the cycle it arrives. The last beat
// of a group loads the middle cell's new value into the output register and
// empties the chain. Reset empties the chain and the counter. Input stalls
// only on a group's last beat while the previous median is still untaken.
module block_median_filter_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [bmf_pkg::TdataW-1:0]  s_axis_tdata,   // [11:0] sample
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [bmf_pkg::TdataW-1:0]  m_axis_tdata    // [11:0] median
);

  bmf_pkg::count_t     count_q, count_d;
  logic                out_vld_q, out_vld_d;
  bmf_pkg::sample_t    out_q, out_d;
  bmf_pkg::sample_t    sample;
  logic                take, last;
  bmf_pkg::cell_ctrl_t ctrl;

  bmf_pkg::link_t   links [bmf_pkg::Window+1];
  bmf_pkg::sample_t vals_d [bmf_pkg::Window];

  assign sample = s_axis_tdata[bmf_pkg::SampleW-1:0];
  assign last   = (count_q == bmf_pkg::CountW'(bmf_pkg::Window - 1));
  assign s_axis_tready = !out_vld_q || m_axis_tready || !last;
  assign take   = s_axis_tvalid && s_axis_tready;
  assign ctrl   = '{en: take, clr: last};

  assign links[0] = '{val: '0, vld: 1'b0, gt: 1'b0};

  for (genvar i = 0; i < bmf_pkg::Window; i++) begin : g_cell
    bmf_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .sample_i (sample),
      .prev_i   (links[i]),
      .link_o   (links[i+1]),
      .val_d_o  (vals_d[i])
    );
  end

  always_comb begin
    count_d   = count_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    if (take) begin
      if (last) begin
        count_d   = '0;
        out_vld_d = 1'b1;
        out_d     = vals_d[bmf_pkg::MidIdx];
      end else begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = bmf_pkg::TdataW'(out_q);

endmodule
